// ===== rtl/e2ep1_pkg.sv =====
// shared types, codes and crc helper for the e2e profile 1 receive check
package e2ep1_pkg;

    localparam logic [5:0] MAX_BYTES = 6'd30;
    localparam logic [7:0] CRC_POLY  = 8'h1D;
    localparam logic [3:0] DELTA_CEIL = 4'd14;

    // status codes
    localparam logic [2:0] ST_NONEW    = 3'd0;
    localparam logic [2:0] ST_WRONGCRC = 3'd1;
    localparam logic [2:0] ST_INITIAL  = 3'd2;
    localparam logic [2:0] ST_OK       = 3'd3;
    localparam logic [2:0] ST_REPEATED = 3'd4;
    localparam logic [2:0] ST_SOMELOST = 3'd5;
    localparam logic [2:0] ST_WRONGSEQ = 3'd6;
    localparam logic [2:0] ST_CFGERR   = 3'd7;

    // register indexes
    localparam logic [2:0] REG_DATA_ID    = 3'd0;
    localparam logic [2:0] REG_ID_MODE    = 3'd1;
    localparam logic [2:0] REG_MSG_BYTES  = 3'd2;
    localparam logic [2:0] REG_CNT_POS    = 3'd3;
    localparam logic [2:0] REG_CRC_POS    = 3'd4;
    localparam logic [2:0] REG_DELTA_INIT = 3'd5;

    // id modes
    localparam logic [1:0] IDM_BOTH   = 2'd0;
    localparam logic [1:0] IDM_ALT    = 2'd1;
    localparam logic [1:0] IDM_LOW    = 2'd2;
    localparam logic [1:0] IDM_NIBBLE = 2'd3;

    typedef struct packed {
        logic [1:0] id_mode;
        logic [4:0] msg_bytes;
        logic [5:0] cnt_pos;
        logic [4:0] crc_pos;
        logic [3:0] delta_init;
        logic       ok;
        logic [7:0] seed_lo;
        logic [7:0] seed_hi;
    } t_cfg;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/e2ep1_cfg.sv =====
// configuration registers, layout check and crc seeds from the data id
module e2ep1_cfg #(
    parameter logic [5:0] MAX_BYTES = e2ep1_pkg::MAX_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output logic              o_cfg_hit,
    output e2ep1_pkg::t_cfg   o_cfg
);

    logic [15:0] r_data_id;
    logic [1:0]  r_id_mode;
    logic [4:0]  r_msg_bytes;
    logic [5:0]  r_cnt_pos;
    logic [4:0]  r_crc_pos;
    logic [3:0]  r_delta_init;
    logic [7:0]  w_lo_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_id    <= 16'd0;
            r_id_mode    <= e2ep1_pkg::IDM_BOTH;
            r_msg_bytes  <= 5'd8;
            r_cnt_pos    <= 6'd2;
            r_crc_pos    <= 5'd0;
            r_delta_init <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                e2ep1_pkg::REG_DATA_ID:    r_data_id    <= i_cfg_data;
                e2ep1_pkg::REG_ID_MODE:    r_id_mode    <= i_cfg_data[1:0];
                e2ep1_pkg::REG_MSG_BYTES:  r_msg_bytes  <= i_cfg_data[4:0];
                e2ep1_pkg::REG_CNT_POS:    r_cnt_pos    <= i_cfg_data[5:0];
                e2ep1_pkg::REG_CRC_POS:    r_crc_pos    <= i_cfg_data[4:0];
                e2ep1_pkg::REG_DELTA_INIT: r_delta_init <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_hit = i_cfg_we && (i_cfg_idx <= e2ep1_pkg::REG_DELTA_INIT);

    assign w_lo_first = e2ep1_pkg::crc8_step(8'd0, r_data_id[7:0]);

    always_comb begin
        o_cfg.id_mode    = r_id_mode;
        o_cfg.msg_bytes  = r_msg_bytes;
        o_cfg.cnt_pos    = r_cnt_pos;
        o_cfg.crc_pos    = r_crc_pos;
        o_cfg.delta_init = r_delta_init;
        o_cfg.ok = !((r_msg_bytes == 5'd0)
                  || ({1'b0, r_msg_bytes} > MAX_BYTES)
                  || (r_crc_pos >= r_msg_bytes)
                  || (({1'b0, r_cnt_pos} + 7'd1) > {1'b0, r_msg_bytes, 1'b0})
                  || (r_crc_pos == r_cnt_pos[5:1]));
        o_cfg.seed_lo = (r_id_mode == e2ep1_pkg::IDM_BOTH)
                      ? e2ep1_pkg::crc8_step(w_lo_first, r_data_id[15:8]) : w_lo_first;
        o_cfg.seed_hi = e2ep1_pkg::crc8_step(8'd0, r_data_id[15:8]);
    end

endmodule

// ===== rtl/e2ep1_core.sv =====
// per-byte crc update, capture, counter sequence check and result register
module e2ep1_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  e2ep1_pkg::t_cfg  i_cfg,
    input  logic             i_cfg_hit,
    input  logic             i_step,
    input  logic             i_func,
    input  logic [7:0]       i_data_byte,
    input  logic             i_adv,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [3:0]       o_lost_count,
    output logic [3:0]       o_seen_counter
);

    logic       r_awaiting_first;
    logic [3:0] r_allowed_delta;
    logic [3:0] r_last_good;
    logic [3:0] r_lost;
    logic [4:0] r_bidx;
    logic [7:0] r_crc_lo;
    logic [7:0] r_crc_hi;
    logic [3:0] r_cap_cnt;
    logic [7:0] r_cap_crc;
    logic       r_out_valid;
    logic [2:0] r_out_status;
    logic [3:0] r_out_lost;
    logic [3:0] r_out_seen;

    logic       n_awaiting_first;
    logic [3:0] n_allowed_delta;
    logic [3:0] n_last_good;
    logic [3:0] n_lost;
    logic [4:0] n_bidx;
    logic [7:0] n_crc_lo;
    logic [7:0] n_crc_hi;
    logic [3:0] n_cap_cnt;
    logic [7:0] n_cap_crc;
    logic       n_res_valid;
    logic [2:0] n_status;
    logic [3:0] n_seen;

    logic [7:0] w_lo_cur;
    logic [7:0] w_hi_cur;
    logic [7:0] w_calc;
    logic [3:0] w_raised;
    logic [3:0] w_delta;

    always_comb begin
        n_awaiting_first = r_awaiting_first;
        n_allowed_delta  = r_allowed_delta;
        n_last_good      = r_last_good;
        n_lost           = r_lost;
        n_bidx           = r_bidx;
        n_crc_lo         = r_crc_lo;
        n_crc_hi         = r_crc_hi;
        n_cap_cnt        = r_cap_cnt;
        n_cap_crc        = r_cap_crc;
        n_res_valid      = 1'b0;
        n_status         = e2ep1_pkg::ST_NONEW;
        n_seen           = 4'd0;
        w_raised = (r_allowed_delta < e2ep1_pkg::DELTA_CEIL)
                 ? r_allowed_delta + 4'd1 : r_allowed_delta;
        w_lo_cur = (r_bidx == 5'd0) ? i_cfg.seed_lo : r_crc_lo;
        w_hi_cur = (r_bidx == 5'd0) ? i_cfg.seed_hi : r_crc_hi;
        w_calc   = 8'd0;
        w_delta  = 4'd0;

        if (!i_cfg.ok) begin
            n_res_valid = 1'b1;
            n_status    = e2ep1_pkg::ST_CFGERR;
        end else if (i_func) begin
            n_allowed_delta = w_raised;
            n_res_valid     = 1'b1;
            n_status        = e2ep1_pkg::ST_NONEW;
        end else begin
            if (r_bidx == i_cfg.crc_pos) begin
                n_cap_crc = i_data_byte;
                n_crc_lo  = w_lo_cur;
                n_crc_hi  = w_hi_cur;
            end else begin
                n_crc_lo = e2ep1_pkg::crc8_step(w_lo_cur, i_data_byte);
                n_crc_hi = e2ep1_pkg::crc8_step(w_hi_cur, i_data_byte);
            end
            if (r_bidx == i_cfg.cnt_pos[5:1]) begin
                n_cap_cnt = i_cfg.cnt_pos[0] ? i_data_byte[7:4] : i_data_byte[3:0];
            end

            if (({1'b0, r_bidx} + 6'd1) < {1'b0, i_cfg.msg_bytes}) begin
                n_bidx = r_bidx + 5'd1;
            end else begin
                // last byte of the message: check crc and counter
                n_bidx          = 5'd0;
                n_allowed_delta = w_raised;
                n_seen          = n_cap_cnt;
                n_res_valid     = 1'b1;
                w_calc = ((i_cfg.id_mode == e2ep1_pkg::IDM_ALT
                        || i_cfg.id_mode == e2ep1_pkg::IDM_NIBBLE) && n_cap_cnt[0])
                       ? n_crc_hi : n_crc_lo;
                // wrap at 15: received minus last, less one when it went around
                w_delta = n_cap_cnt - r_last_good
                        - {3'd0, (n_cap_cnt < r_last_good)};
                if (w_calc != n_cap_crc) begin
                    n_status = e2ep1_pkg::ST_WRONGCRC;
                end else if (r_awaiting_first) begin
                    n_awaiting_first = 1'b0;
                    n_allowed_delta  = i_cfg.delta_init;
                    n_last_good      = n_cap_cnt;
                    n_status         = e2ep1_pkg::ST_INITIAL;
                end else if (w_delta == 4'd1) begin
                    n_allowed_delta = i_cfg.delta_init;
                    n_last_good     = n_cap_cnt;
                    n_lost          = 4'd0;
                    n_status        = e2ep1_pkg::ST_OK;
                end else if (w_delta == 4'd0) begin
                    n_status = e2ep1_pkg::ST_REPEATED;
                end else if (w_delta <= w_raised) begin
                    n_allowed_delta = i_cfg.delta_init;
                    n_last_good     = n_cap_cnt;
                    n_lost          = w_delta - 4'd1;
                    n_status        = e2ep1_pkg::ST_SOMELOST;
                end else begin
                    n_status = e2ep1_pkg::ST_WRONGSEQ;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting_first <= 1'b1;
            r_allowed_delta  <= 4'd0;
            r_last_good      <= 4'd0;
            r_lost           <= 4'd0;
            r_bidx           <= 5'd0;
            r_crc_lo         <= 8'd0;
            r_crc_hi         <= 8'd0;
            r_cap_cnt        <= 4'd0;
            r_cap_crc        <= 8'd0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_hit) begin
                r_bidx <= 5'd0;
            end else if (i_step) begin
                r_awaiting_first <= n_awaiting_first;
                r_allowed_delta  <= n_allowed_delta;
                r_last_good      <= n_last_good;
                r_lost           <= n_lost;
                r_bidx           <= n_bidx;
                r_crc_lo         <= n_crc_lo;
                r_crc_hi         <= n_crc_hi;
                r_cap_cnt        <= n_cap_cnt;
                r_cap_crc        <= n_cap_crc;
            end
            if (i_adv) begin
                r_out_valid <= i_step && n_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_step && n_res_valid) begin
            r_out_status <= n_status;
            r_out_lost   <= n_lost;
            r_out_seen   <= n_seen;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_lost_count   = r_out_lost;
    assign o_seen_counter = r_out_seen;

endmodule

// ===== rtl/e2e_profile1_check.sv =====
// top level of the e2e profile 1 receive check: input register and wiring
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------------
//  in      | i_valid | o_stall | i_func, i_data_byte
//  out     | o_valid | i_stall | o_status, o_lost_count, o_seen_counter
//  cfg     | i_cfg_we| -       | i_cfg_idx, i_cfg_data
//
// one beat per cycle unless stalled; a result is registered after its last byte
// the input register and the result register are the two pipeline stages
// a stalled result holds both stages; the input stage still takes a beat if empty
// reset is synchronous and needs no clearing pass; the block is usable next cycle
module e2e_profile1_check #(
    parameter logic [5:0] MAX_BYTES = e2ep1_pkg::MAX_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_lost_count,
    output logic [3:0]  o_seen_counter,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    e2ep1_pkg::t_cfg w_cfg;
    logic            w_cfg_hit;
    logic            w_adv;
    logic            r_in_valid;
    logic            r_func;
    logic [7:0]      r_byte;

    e2ep1_cfg #(
        .MAX_BYTES (MAX_BYTES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg_hit  (w_cfg_hit),
        .o_cfg      (w_cfg)
    );

    // the result register can load when empty or being taken
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_func <= i_func;
            r_byte <= i_data_byte;
        end
    end

    e2ep1_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cfg_hit      (w_cfg_hit),
        .i_step         (r_in_valid && w_adv),
        .i_func         (r_func),
        .i_data_byte    (r_byte),
        .i_adv          (w_adv),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_lost_count   (o_lost_count),
        .o_seen_counter (o_seen_counter)
    );

endmodule

// ===== rtl/e2ep1_chk.sv =====
// port-level checks for the e2e profile 1 receive check, bound to the top level
module e2ep1_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [3:0]  o_lost_count,
    input logic [3:0]  o_seen_counter
);

    // a result held by stall keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_lost_count) && $stable(o_seen_counter))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // poll and config error carry no counter
    a_no_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == e2ep1_pkg::ST_NONEW || o_status == e2ep1_pkg::ST_CFGERR)
            |-> o_seen_counter == 4'd0)
        else $error("counter reported without message");

    a_ok_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == e2ep1_pkg::ST_OK |-> o_lost_count == 4'd0)
        else $error("ok status with lost messages");

    a_lost_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_lost_count != 4'd15)
        else $error("lost count out of range");

endmodule

bind e2e_profile1_check e2ep1_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_lost_count   (o_lost_count),
    .o_seen_counter (o_seen_counter)
);

// ===== test/e2e_profile1_check_test.sv =====
// self-checking testbench for the e2e profile 1 receive check
`timescale 1ns / 100ps

module e2e_profile1_check_test;

    localparam logic FN_BYTE = 1'b0;
    localparam logic FN_POLL = 1'b1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LAYOUT_WIDE = 0;
    localparam int LAYOUT_BAD = 3;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] lost;
        logic [3:0] seen;
    } t_chk_result;

    typedef enum logic [1:0] {ACT_BYTE, ACT_POLL, ACT_CRC, ACT_CFG} t_row_act;

    typedef struct packed {
        t_row_act   act;
        logic [2:0] idx;
        logic [15:0] val;
        logic       pinned;
        logic [2:0] pinned_status;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_func = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_lost_count;
    logic [3:0]  o_seen_counter;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = 3'd0;
    logic [15:0] i_cfg_data = 16'h0000;

    // predictor copy of the registers
    logic [15:0] cfg_id = 16'h0000;
    logic [1:0]  cfg_mode = e2ep1_pkg::IDM_BOTH;
    logic [4:0]  cfg_len = 5'd8;
    logic [5:0]  cfg_cnt_pos = 6'd2;
    logic [4:0]  cfg_crc_pos = 5'd0;
    logic [3:0]  cfg_delta = 4'd1;

    // predictor copy of the check state
    logic        first_pending = 1'b1;
    logic [3:0]  delta_allow = 4'd0;
    logic [3:0]  last_cnt = 4'd0;
    logic [3:0]  lost_cnt = 4'd0;
    logic [4:0]  pos = 5'd0;
    logic [7:0]  crc_a = 8'h00;
    logic [7:0]  crc_b = 8'h00;
    logic [3:0]  cnt_cap = 4'd0;
    logic [7:0]  crc_cap = 8'h00;

    t_chk_result due_results[$];
    logic [7:0]  frame [0:31];
    int          tx_ctr = 0;
    int          snd_idle_pct = 27;
    int          rcv_stall_pct = 86;
    int          cycles = 0;
    int          errors = 0;
    int          beats_sent = 0;
    int          results_checked = 0;

    e2e_profile1_check uut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     due_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic logic [7:0] crc8_1d(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ b[k];
            c = {c[6:0], 1'b0} ^ (fb ? e2ep1_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic bit layout_ok();
        if (cfg_len == 0 || cfg_len > e2ep1_pkg::MAX_BYTES) return 1'b0;
        if (cfg_crc_pos >= cfg_len) return 1'b0;
        if (int'(cfg_cnt_pos) + 1 > 2 * int'(cfg_len)) return 1'b0;
        if (cfg_crc_pos == cfg_cnt_pos[5:1]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_dir_row mk_row(input t_row_act act, input logic [2:0] idx,
                                        input logic [15:0] val, input logic pinned,
                                        input logic [2:0] st);
        t_dir_row r;
        r.act = act;
        r.idx = idx;
        r.val = val;
        r.pinned = pinned;
        r.pinned_status = st;
        return r;
    endfunction

    // advances the check state by one beat; has is low while a message is incomplete
    task automatic judge_beat(input logic fn, input logic [7:0] b, output bit has,
                              output t_chk_result r);
        logic [7:0] calc;
        logic [3:0] dlt;
        has = 1'b1;
        r.status = e2ep1_pkg::ST_CFGERR;
        r.lost = lost_cnt;
        r.seen = 4'd0;
        if (!layout_ok()) return;
        if (fn == FN_POLL) begin
            if (delta_allow < e2ep1_pkg::DELTA_CEIL) delta_allow++;
            r.status = e2ep1_pkg::ST_NONEW;
            return;
        end
        if (pos == 0) begin
            crc_a = crc8_1d(8'h00, cfg_id[7:0]);
            if (cfg_mode == e2ep1_pkg::IDM_BOTH) crc_a = crc8_1d(crc_a, cfg_id[15:8]);
            crc_b = crc8_1d(8'h00, cfg_id[15:8]);
        end
        if (pos == cfg_crc_pos) begin
            crc_cap = b;
        end else begin
            crc_a = crc8_1d(crc_a, b);
            crc_b = crc8_1d(crc_b, b);
        end
        if (pos == cfg_cnt_pos[5:1]) cnt_cap = cfg_cnt_pos[0] ? b[7:4] : b[3:0];
        if (int'(pos) + 1 < int'(cfg_len)) begin
            pos++;
            has = 1'b0;
            return;
        end
        pos = 5'd0;
        if (delta_allow < e2ep1_pkg::DELTA_CEIL) delta_allow++;
        r.seen = cnt_cap;
        calc = ((cfg_mode == e2ep1_pkg::IDM_ALT || cfg_mode == e2ep1_pkg::IDM_NIBBLE)
                && cnt_cap[0]) ? crc_b : crc_a;
        if (calc != crc_cap) begin
            r.status = e2ep1_pkg::ST_WRONGCRC;
        end else if (first_pending) begin
            first_pending = 1'b0;
            delta_allow = cfg_delta;
            last_cnt = cnt_cap;
            r.status = e2ep1_pkg::ST_INITIAL;
        end else begin
            // counter runs modulo 15
            dlt = (cnt_cap >= last_cnt) ? cnt_cap - last_cnt : 4'd15 + cnt_cap - last_cnt;
            if (dlt == 4'd1) begin
                delta_allow = cfg_delta;
                last_cnt = cnt_cap;
                lost_cnt = 4'd0;
                r.status = e2ep1_pkg::ST_OK;
            end else if (dlt == 4'd0) begin
                r.status = e2ep1_pkg::ST_REPEATED;
            end else if (dlt <= delta_allow) begin
                delta_allow = cfg_delta;
                last_cnt = cnt_cap;
                lost_cnt = dlt - 4'd1;
                r.status = e2ep1_pkg::ST_SOMELOST;
            end else begin
                r.status = e2ep1_pkg::ST_WRONGSEQ;
            end
        end
        r.lost = lost_cnt;
    endtask

    task automatic send_beat(input logic fn, input logic [7:0] b, input logic pinned,
                             input logic [2:0] pinned_status);
        bit          has;
        t_chk_result r;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        judge_beat(fn, b, has, r);
        if (pinned) begin
            has = 1'b1;
            r.status = pinned_status;
            r.lost = 4'd0;
            r.seen = 4'd0;
        end
        if (has) due_results.push_back(r);
        beats_sent++;
    endtask

    // caller lowers the write enable after the last register
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            e2ep1_pkg::REG_DATA_ID:    cfg_id = val;
            e2ep1_pkg::REG_ID_MODE:    cfg_mode = val[1:0];
            e2ep1_pkg::REG_MSG_BYTES:  cfg_len = val[4:0];
            e2ep1_pkg::REG_CNT_POS:    cfg_cnt_pos = val[5:0];
            e2ep1_pkg::REG_CRC_POS:    cfg_crc_pos = val[4:0];
            e2ep1_pkg::REG_DELTA_INIT: cfg_delta = val[3:0];
            default: ;
        endcase
        pos = 5'd0;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        // trailing bytes give no result, let them clear the pipeline
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_traffic(input int budget);
        int         stop_at;
        int         roll;
        int         cb;
        int         n;
        logic [7:0] lo;
        logic [7:0] hi;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at) begin
            if (!layout_ok()) begin
                send_beat(logic'($urandom_range(1)), 8'($urandom_range(255)), 1'b0,
                          e2ep1_pkg::ST_NONEW);
                continue;
            end
            // realign after noise or a cut message
            while (pos != 0)
                send_beat(FN_BYTE, 8'($urandom_range(255)), 1'b0, e2ep1_pkg::ST_NONEW);
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_beat(FN_POLL, 8'($urandom_range(255)), 1'b0, e2ep1_pkg::ST_NONEW);
            end else if (roll < 14) begin
                repeat ($urandom_range(1, 3))
                    send_beat(FN_BYTE, 8'($urandom_range(255)), 1'b0, e2ep1_pkg::ST_NONEW);
            end else begin
                n = $urandom_range(99);
                if (n < 70) tx_ctr = (tx_ctr + 1) % 15;
                else if (n < 78) tx_ctr = tx_ctr;
                else if (n < 90) tx_ctr = (tx_ctr + $urandom_range(2, 6)) % 15;
                else tx_ctr = $urandom_range(15);
                for (int i = 0; i < cfg_len; i++) frame[i] = 8'($urandom_range(255));
                cb = int'(cfg_cnt_pos[5:1]);
                if (cfg_cnt_pos[0]) frame[cb][7:4] = tx_ctr[3:0];
                else frame[cb][3:0] = tx_ctr[3:0];
                lo = crc8_1d(8'h00, cfg_id[7:0]);
                if (cfg_mode == e2ep1_pkg::IDM_BOTH) lo = crc8_1d(lo, cfg_id[15:8]);
                hi = crc8_1d(8'h00, cfg_id[15:8]);
                for (int i = 0; i < cfg_len; i++) begin
                    if (i != cfg_crc_pos) begin
                        lo = crc8_1d(lo, frame[i]);
                        hi = crc8_1d(hi, frame[i]);
                    end
                end
                frame[cfg_crc_pos] = ((cfg_mode == e2ep1_pkg::IDM_ALT
                                       || cfg_mode == e2ep1_pkg::IDM_NIBBLE)
                                      && tx_ctr[0]) ? hi : lo;
                if (roll < 22) frame[cfg_crc_pos] ^= 8'($urandom_range(1, 255));
                n = (roll >= 97) ? $urandom_range(cfg_len - 1) : cfg_len;
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(99) < 3)
                        send_beat(FN_POLL, 8'($urandom_range(255)), 1'b0,
                                  e2ep1_pkg::ST_NONEW);
                    send_beat(FN_BYTE, frame[i], 1'b0, e2ep1_pkg::ST_NONEW);
                end
            end
        end
    endtask

    // receiver side: random stall and result checking
    always @(posedge i_clk) begin : result_check
        t_chk_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d lost %0d seen %0d",
                                          o_status, o_lost_count, o_seen_counter));
            end else begin
                want = due_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_lost_count !== want.lost)
                    report_mismatch($sformatf("lost_count %0d, want %0d", o_lost_count,
                                              want.lost));
                if (o_seen_counter !== want.seen)
                    report_mismatch($sformatf("seen_counter %0d, want %0d", o_seen_counter,
                                              want.seen));
            end
        end
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    initial begin : stimulus
        t_dir_row    dir_table[$];
        int          layouts;
        logic [15:0] id;
        logic [1:0]  mode;
        int          len;
        int          crc;
        int          cb;
        int          cnt;
        int          dinit;
        layouts = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_table.push_back(mk_row(ACT_POLL, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b1,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_MSG_BYTES, 16'd31, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b1,
                                   e2ep1_pkg::ST_CFGERR));
        dir_table.push_back(mk_row(ACT_POLL, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b1,
                                   e2ep1_pkg::ST_CFGERR));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_MSG_BYTES, 16'd0, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h00FF, 1'b1,
                                   e2ep1_pkg::ST_CFGERR));
        // counter and crc land in the same byte
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_MSG_BYTES, 16'd2, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_CNT_POS, 16'd0, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h005A, 1'b1,
                                   e2ep1_pkg::ST_CFGERR));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_CRC_POS, 16'd1, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_DATA_ID, 16'hFFFF, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_ID_MODE,
                                   16'(e2ep1_pkg::IDM_ALT), 1'b0, e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_DELTA_INIT, 16'd15, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        // first message with counter 15, poll in the middle of it
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h000F, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_POLL, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b1,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CRC, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h00F0, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CRC, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h0001, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CRC, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h000F, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CRC, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h0005, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        // register write drops the half message
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h0033, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_ID_MODE,
                                   16'(e2ep1_pkg::IDM_NIBBLE), 1'b0, e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h0002, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CRC, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_DELTA_INIT, 16'd0, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CFG, e2ep1_pkg::REG_ID_MODE,
                                   16'(e2ep1_pkg::IDM_LOW), 1'b0, e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h0003, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CRC, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_BYTE, e2ep1_pkg::REG_DATA_ID, 16'h0005, 1'b0,
                                   e2ep1_pkg::ST_NONEW));
        dir_table.push_back(mk_row(ACT_CRC, e2ep1_pkg::REG_DATA_ID, 16'h0000, 1'b0,
                                   e2ep1_pkg::ST_NONEW));

        foreach (dir_table[k]) begin
            if (dir_table[k].act == ACT_CFG) begin
                if (k == 0 || dir_table[k - 1].act != ACT_CFG) drain_results();
                write_reg(dir_table[k].idx, dir_table[k].val);
            end else begin
                i_cfg_we <= 1'b0;
                case (dir_table[k].act)
                    ACT_POLL: send_beat(FN_POLL, dir_table[k].val[7:0], dir_table[k].pinned,
                                        dir_table[k].pinned_status);
                    ACT_CRC: send_beat(FN_BYTE,
                                       ((cfg_mode == e2ep1_pkg::IDM_ALT
                                         || cfg_mode == e2ep1_pkg::IDM_NIBBLE)
                                        && cnt_cap[0]) ? crc_b : crc_a, 1'b0,
                                       e2ep1_pkg::ST_NONEW);
                    default: send_beat(FN_BYTE, dir_table[k].val[7:0], dir_table[k].pinned,
                                       dir_table[k].pinned_status);
                endcase
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 86 : 0;
            rcv_stall_pct = (ph == 0) ? 86 : (ph == 1) ? 27 : 0;
            for (int s = 0; s < 4; s++) begin
                id = 16'($urandom_range(16'hFFFF));
                mode = 2'($urandom_range(3));
                dinit = $urandom_range(15);
                len = $urandom_range(2, 6);
                crc = $urandom_range(len - 1);
                cb = (crc + $urandom_range(1, len - 1)) % len;
                cnt = 2 * cb + $urandom_range(1);
                if (s == LAYOUT_WIDE) begin
                    len = e2ep1_pkg::MAX_BYTES;
                    if (ph == 1) begin
                        crc = len - 1;
                        cnt = 0;
                    end else begin
                        crc = 0;
                        cnt = 2 * len - 1;
                    end
                    id = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : id;
                    dinit = (ph == 0) ? 0 : (ph == 1) ? 15 : 14;
                end else if (s == LAYOUT_BAD) begin
                    case ($urandom_range(4))
                        0: len = 0;
                        1: len = 31;
                        2: crc = $urandom_range(len, 31);
                        3: cnt = $urandom_range(2 * len, 63);
                        default: cnt = 2 * crc + $urandom_range(1);
                    endcase
                end
                drain_results();
                write_reg(e2ep1_pkg::REG_DATA_ID, id);
                write_reg(e2ep1_pkg::REG_ID_MODE, 16'(mode));
                write_reg(e2ep1_pkg::REG_MSG_BYTES, 16'(len));
                write_reg(e2ep1_pkg::REG_CNT_POS, 16'(cnt));
                write_reg(e2ep1_pkg::REG_CRC_POS, 16'(crc));
                write_reg(e2ep1_pkg::REG_DELTA_INIT, 16'(dinit));
                i_cfg_we <= 1'b0;
                layouts++;
                if (s == LAYOUT_BAD) begin
                    run_traffic(10);
                end else if (s == LAYOUT_WIDE) begin
                    run_traffic(62);
                end else if (ph == 1 && s == 1) begin
                    // hold the sender until the output side has caught up
                    run_traffic(45);
                    drain_results();
                    run_traffic(45);
                end else begin
                    run_traffic(90);
                end
            end
        end

        drain_results();
        $display("covered %0d beats over %0d random layouts plus the directed table",
                 beats_sent, layouts);
        $display("%0d results checked across three stall mixes, %0d mismatches",
                 results_checked, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
